@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk_i outside reset.
`define SOA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/soa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab object allocator package
// Sizes, codes and the command and status types shared by the allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int MAX_SLABS     = 16;
  localparam int MAX_OBJECTS   = 512;
  localparam int POINTER_BYTES = 8;
  localparam int ADDR_W        = 32;

  localparam int SLOT_W      = $clog2(MAX_SLABS);
  localparam int IDX_W       = $clog2(MAX_OBJECTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int LEN_W       = SLOT_W + 1;
  localparam int STACK_AW    = SLOT_W + IDX_W;
  localparam int STACK_DEPTH = MAX_SLABS * MAX_OBJECTS;
  localparam int NUM_LISTS   = 3;

  localparam int SIZE_W  = 13;
  localparam int OSZ_W   = 14;
  localparam int PAGE_W  = 17;
  localparam int CFG_W   = 17;
  localparam int CFG_IW  = 2;
  localparam int TOT_W   = 14;
  localparam int SC_W    = 5;
  localparam int STAT_W  = 3;
  localparam int PROD_W  = CNT_W + OSZ_W;
  localparam int DCNT_W  = $clog2(PAGE_W + 1);

  localparam logic [SIZE_W-1:0] RST_OBJECT_SIZE  = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] RST_OBJECT_ALIGN = SIZE_W'(8);
  localparam logic [PAGE_W-1:0] RST_PAGE_SIZE    = PAGE_W'(4096);

  typedef enum logic [1:0] {
    OP_ADD,
    OP_ALLOC,
    OP_FREE,
    OP_SHRINK
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_ZERO_CAP,
    ST_NONE_FREE,
    ST_NOT_OWNED,
    ST_TABLE_FULL,
    ST_ALREADY_FREE,
    ST_NOTHING_RELEASED
  } status_e;

  typedef enum logic [1:0] {
    LIST_PARTIAL,
    LIST_FULL,
    LIST_EMPTY
  } list_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_OBJECT_SIZE,
    CFG_OBJECT_ALIGN,
    CFG_PAGE_SIZE,
    CFG_RELEASE_ENABLED
  } cfg_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ADD,
    ACT_ALLOC_PICK,
    ACT_ALLOC,
    ACT_FREE_SCAN,
    ACT_FREE,
    ACT_SHRINK_NONE,
    ACT_SHRINK_POP
  } act_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_DIV,
    S_ADD_DO,
    S_ALLOC_PICK,
    S_ALLOC_DO,
    S_FREE_SCAN,
    S_FREE_DO,
    S_SHRINK_CHK,
    S_SHRINK_POP
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    act_e act;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic shrink_none;
    logic shrink_last;
  } sts_t;

endpackage

@@ hw/rtl/soa_in_if.sv @@
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocator request.
// ----------------------------------------------------------------------------
interface soa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] page_base;
  logic [31:0] object_address;

  modport source(output valid, output opcode, output page_base, output object_address,
                 input ready);
  modport sink(input valid, input opcode, input page_base, input object_address,
               output ready);
endinterface

@@ hw/rtl/soa_out_if.sv @@
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one allocator response.
// ----------------------------------------------------------------------------
interface soa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] result_address;
  logic        last;
  logic [4:0]  released_count;
  logic [13:0] free_objects;
  logic [13:0] allocated_objects;
  logic [4:0]  slab_count;

  modport source(output valid, output status, output result_address, output last,
                 output released_count, output free_objects, output allocated_objects,
                 output slab_count, input ready);
  modport sink(input valid, input status, input result_address, input last,
               input released_count, input free_objects, input allocated_objects,
               input slab_count, output ready);
endinterface

@@ hw/rtl/slab_object_allocator.sv @@
// ----------------------------------------------------------------------------
// Slab object allocator
// Fixed-size object allocator over a table of up to sixteen slab pages.
// ----------------------------------------------------------------------------
// One request is processed at a time; a new request is taken as soon as the
// previous one has placed its last response in the output register. Allocate
// and free each first pick the slab (head lookup and stack read, or page range
// compare across all slabs) and then commit. Add slab waits on the bit-serial
// divider that computes the slab capacity from page size and object size
// (seventeen steps). Shrink checks the empty list and, if release is enabled,
// releases its slabs one by one with a response each. The free address stacks
// live in an 8192-entry memory; entries a slab has never handed out are
// recomputed from the page base, so no clearing pass follows reset.
`include "assert_macros.svh"

module slab_object_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [soa_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [soa_pkg::CFG_W-1:0]  cfg_wdata_i,
  soa_in_if.sink                     req_i,
  soa_out_if.source                  rsp_o
);

  soa_pkg::cmd_t cmd;
  soa_pkg::sts_t sts;

  soa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_opcode_i (soa_pkg::op_e'(req_i.opcode)),
    .in_ready_o  (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  soa_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .page_base_i         (req_i.page_base),
    .object_address_i    (req_i.object_address),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .status_o            (rsp_o.status),
    .result_address_o    (rsp_o.result_address),
    .last_o              (rsp_o.last),
    .released_count_o    (rsp_o.released_count),
    .free_objects_o      (rsp_o.free_objects),
    .allocated_objects_o (rsp_o.allocated_objects),
    .slab_count_o        (rsp_o.slab_count)
  );

  `SOA_ASSERT_IMP(a_no_accept_while_busy, cmd.act != soa_pkg::ACT_NONE, !req_i.ready, "request accepted while an operation is in progress")
  `SOA_ASSERT_IMP(a_no_overwrite, rsp_o.valid && !rsp_o.ready, cmd.act == soa_pkg::ACT_NONE || cmd.act == soa_pkg::ACT_ALLOC_PICK || cmd.act == soa_pkg::ACT_FREE_SCAN, "response register overwritten while stalled")
  `SOA_ASSERT_IMP(a_only_shrink_continues, rsp_o.valid && !rsp_o.last, rsp_o.status == soa_pkg::ST_OK && rsp_o.released_count != '0, "non-final response outside a shrink")
  `SOA_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready, "request taken in consecutive cycles")

endmodule

@@ hw/rtl/soa_div.sv @@
// ----------------------------------------------------------------------------
// Slab capacity divider
// Restoring divider, one quotient bit per cycle: page size over object size.
// ----------------------------------------------------------------------------
module soa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [soa_pkg::PAGE_W-1:0]  dividend_i,
  input  logic [soa_pkg::OSZ_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [soa_pkg::PAGE_W-1:0]  quot_o
);

  logic [soa_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [soa_pkg::OSZ_W-1:0]  rem_q, rem_d;
  logic [soa_pkg::PAGE_W-1:0] quot_q, quot_d;
  logic [soa_pkg::OSZ_W:0]    trial;
  logic                       ge;

  always_comb begin
    trial  = {rem_q, quot_q[soa_pkg::PAGE_W-1]};
    ge     = trial >= {1'b0, divisor_i};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      cnt_d  = soa_pkg::DCNT_W'(soa_pkg::PAGE_W);
      busy_d = 1'b1;
      done_d = 1'b0;
      rem_d  = '0;
      quot_d = dividend_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the difference fits.
      rem_d  = ge ? soa_pkg::OSZ_W'(trial - {1'b0, divisor_i}) : trial[soa_pkg::OSZ_W-1:0];
      quot_d = {quot_q[soa_pkg::PAGE_W-2:0], ge};
      cnt_d  = cnt_q - soa_pkg::DCNT_W'(1);
      if (cnt_q == soa_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/soa_dp.sv @@
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Slab table, slab lists, free address stacks, totals and response register.
// ----------------------------------------------------------------------------
module soa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [soa_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [soa_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [soa_pkg::ADDR_W-1:0]  page_base_i,
  input  logic [soa_pkg::ADDR_W-1:0]  object_address_i,
  input  soa_pkg::cmd_t               cmd_i,
  output soa_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [soa_pkg::STAT_W-1:0]  status_o,
  output logic [soa_pkg::ADDR_W-1:0]  result_address_o,
  output logic                        last_o,
  output logic [soa_pkg::SC_W-1:0]    released_count_o,
  output logic [soa_pkg::TOT_W-1:0]   free_objects_o,
  output logic [soa_pkg::TOT_W-1:0]   allocated_objects_o,
  output logic [soa_pkg::SC_W-1:0]    slab_count_o
);

  localparam int NS = soa_pkg::MAX_SLABS;
  localparam int NL = soa_pkg::NUM_LISTS;

  // Configuration.
  logic [soa_pkg::SIZE_W-1:0] size_q, align_q;
  logic [soa_pkg::PAGE_W-1:0] page_size_q;
  logic                       rel_en_q;

  // Latched request.
  logic [soa_pkg::ADDR_W-1:0] page_in_q, addr_in_q;

  // Slab table.
  logic [NS-1:0]              valid_q;
  logic [soa_pkg::ADDR_W-1:0] page_q  [NS];
  logic [soa_pkg::CNT_W-1:0]  nfree_q [NS];
  logic [soa_pkg::CNT_W-1:0]  cap_q   [NS];
  logic [soa_pkg::OSZ_W-1:0]  osz_q   [NS];
  logic [soa_pkg::CNT_W-1:0]  low_q   [NS];

  // Slab lists, head at the top of each.
  logic [soa_pkg::SLOT_W-1:0] list_q [NL][NS];
  logic [soa_pkg::SLOT_W-1:0] list_d [NL][NS];
  logic [soa_pkg::LEN_W-1:0]  len_q  [NL];
  logic [soa_pkg::LEN_W-1:0]  len_d  [NL];

  logic [soa_pkg::TOT_W-1:0]  tf_q, tf_d, ta_q, ta_d;
  logic [soa_pkg::SC_W-1:0]   sc_q, sc_d, rel_q, rel_d;

  // Free address stacks.
  logic [soa_pkg::ADDR_W-1:0]   stack_mem [soa_pkg::STACK_DEPTH];
  logic [soa_pkg::ADDR_W-1:0]   mem_rd_q;
  logic                         mem_we, mem_re;
  logic [soa_pkg::STACK_AW-1:0] mem_wa, mem_ra;
  logic [soa_pkg::ADDR_W-1:0]   mem_wd;

  // Allocation pick stage.
  logic [soa_pkg::SLOT_W-1:0] a_slot_q;
  logic                       a_none_q, a_impl_q;
  logic [soa_pkg::PROD_W-1:0] prod_q;
  logic [NS-1:0]              own_q;

  // Response register.
  logic                       out_valid_q;
  soa_pkg::status_e           o_status_q, o_status;
  logic [soa_pkg::ADDR_W-1:0] o_addr_q, o_addr;
  logic                       o_last_q, o_last;
  logic [soa_pkg::SC_W-1:0]   o_rel_q, o_rel;
  logic                       emit;
  logic                       out_free;

  // Object size and capacity.
  logic [soa_pkg::SIZE_W-1:0] osz_eff, al_eff, al_m1;
  logic [soa_pkg::OSZ_W-1:0]  rounded;
  logic [soa_pkg::PAGE_W-1:0] quot;
  logic                       div_done;
  logic [soa_pkg::CNT_W-1:0]  cap;
  logic                       cap_zero;
  logic [soa_pkg::SLOT_W-1:0] free_slot;
  logic                       table_full;

  // Head selection.
  logic [soa_pkg::SLOT_W-1:0] head_p, head_e, pick_slot;
  logic                       has_p, has_e;
  logic [soa_pkg::CNT_W-1:0]  pick_n, pick_idx_w;
  logic [soa_pkg::IDX_W-1:0]  pick_idx;

  // Owner search.
  logic                       f_found;
  logic [soa_pkg::SLOT_W-1:0] f_slot;
  soa_pkg::list_e             f_src;
  logic [soa_pkg::CNT_W-1:0]  f_n, a_n;

  // Per-cycle updates.
  logic [NL-1:0]              rem_en, push_en, pop_en;
  logic [soa_pkg::SLOT_W-1:0] mv_slot;
  logic                       add_en, nf_we, clr_en;
  logic [soa_pkg::SLOT_W-1:0] nf_slot;
  logic [soa_pkg::CNT_W-1:0]  nf_val, low_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= soa_pkg::RST_OBJECT_SIZE;
      align_q     <= soa_pkg::RST_OBJECT_ALIGN;
      page_size_q <= soa_pkg::RST_PAGE_SIZE;
      rel_en_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (soa_pkg::cfg_e'(cfg_idx_i))
        soa_pkg::CFG_OBJECT_SIZE:     size_q      <= cfg_wdata_i[soa_pkg::SIZE_W-1:0];
        soa_pkg::CFG_OBJECT_ALIGN:    align_q     <= cfg_wdata_i[soa_pkg::SIZE_W-1:0];
        soa_pkg::CFG_PAGE_SIZE:       page_size_q <= cfg_wdata_i[soa_pkg::PAGE_W-1:0];
        soa_pkg::CFG_RELEASE_ENABLED: rel_en_q    <= cfg_wdata_i[0];
      endcase
    end
  end

  always_comb begin
    osz_eff = (size_q < soa_pkg::SIZE_W'(soa_pkg::POINTER_BYTES)) ?
              soa_pkg::SIZE_W'(soa_pkg::POINTER_BYTES) : size_q;
    al_eff  = (align_q < soa_pkg::SIZE_W'(soa_pkg::POINTER_BYTES)) ?
              soa_pkg::SIZE_W'(soa_pkg::POINTER_BYTES) : align_q;
    al_m1   = al_eff - soa_pkg::SIZE_W'(1);
    rounded = ({1'b0, osz_eff} + {1'b0, al_m1}) & ~{1'b0, al_m1};
  end

  soa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (page_size_q),
    .divisor_i  (rounded),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    cap = (quot >= soa_pkg::PAGE_W'(soa_pkg::MAX_OBJECTS)) ?
          soa_pkg::CNT_W'(soa_pkg::MAX_OBJECTS) : quot[soa_pkg::CNT_W-1:0];
    cap_zero   = (rounded == '0) || (cap == '0);
    table_full = &valid_q;
    free_slot  = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = soa_pkg::SLOT_W'(i);
    end
  end

  always_comb begin
    has_p  = len_q[soa_pkg::LIST_PARTIAL] != '0;
    has_e  = len_q[soa_pkg::LIST_EMPTY] != '0;
    head_p = list_q[soa_pkg::LIST_PARTIAL]
                   [soa_pkg::SLOT_W'(len_q[soa_pkg::LIST_PARTIAL] - soa_pkg::LEN_W'(1))];
    head_e = list_q[soa_pkg::LIST_EMPTY]
                   [soa_pkg::SLOT_W'(len_q[soa_pkg::LIST_EMPTY] - soa_pkg::LEN_W'(1))];
    pick_slot  = has_p ? head_p : head_e;
    pick_n     = nfree_q[pick_slot];
    pick_idx_w = pick_n - soa_pkg::CNT_W'(1);
    pick_idx   = pick_idx_w[soa_pkg::IDX_W-1:0];
    a_n        = nfree_q[a_slot_q];
  end

  // Owner search: partial, full, then empty list, each from its head.
  always_comb begin
    f_found = 1'b0;
    f_slot  = '0;
    f_src   = soa_pkg::LIST_PARTIAL;
    for (int l = NL - 1; l >= 0; l--) begin
      for (int p = 0; p < NS; p++) begin
        if ((soa_pkg::LEN_W'(p) < len_q[l]) && own_q[list_q[l][p]]) begin
          f_found = 1'b1;
          f_slot  = list_q[l][p];
          f_src   = soa_pkg::list_e'(l);
        end
      end
    end
    f_n = nfree_q[f_slot];
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    rem_en   = '0;
    push_en  = '0;
    pop_en   = '0;
    mv_slot  = '0;
    add_en   = 1'b0;
    nf_we    = 1'b0;
    clr_en   = 1'b0;
    nf_slot  = '0;
    nf_val   = '0;
    low_val  = '0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = addr_in_q;
    mem_re   = 1'b0;
    mem_ra   = {pick_slot, pick_idx};
    tf_d     = tf_q;
    ta_d     = ta_q;
    sc_d     = sc_q;
    rel_d    = cmd_i.load ? '0 : rel_q;
    emit     = 1'b0;
    o_status = soa_pkg::ST_OK;
    o_addr   = '0;
    o_last   = 1'b1;
    o_rel    = '0;
    unique case (cmd_i.act)
      soa_pkg::ACT_ADD: begin
        emit = 1'b1;
        if (cap_zero) begin
          o_status = soa_pkg::ST_ZERO_CAP;
        end else if (table_full) begin
          o_status = soa_pkg::ST_TABLE_FULL;
        end else begin
          add_en                      = 1'b1;
          mv_slot                     = free_slot;
          push_en[soa_pkg::LIST_EMPTY] = 1'b1;
          sc_d                        = sc_q + soa_pkg::SC_W'(1);
          tf_d                        = tf_q + soa_pkg::TOT_W'(cap);
        end
      end
      soa_pkg::ACT_ALLOC_PICK: begin
        mem_re = has_p || has_e;
        if (!has_p && has_e) begin
          // Promote the head empty slab to the partial list.
          pop_en[soa_pkg::LIST_EMPTY]    = 1'b1;
          push_en[soa_pkg::LIST_PARTIAL] = 1'b1;
          mv_slot                        = head_e;
        end
      end
      soa_pkg::ACT_ALLOC: begin
        emit = 1'b1;
        if (a_none_q || a_n == '0) begin
          o_status = soa_pkg::ST_NONE_FREE;
        end else begin
          o_addr  = a_impl_q ? page_q[a_slot_q] + soa_pkg::ADDR_W'(prod_q) : mem_rd_q;
          nf_we   = 1'b1;
          nf_slot = a_slot_q;
          nf_val  = a_n - soa_pkg::CNT_W'(1);
          low_val = (nf_val < low_q[a_slot_q]) ? nf_val : low_q[a_slot_q];
          tf_d    = tf_q - soa_pkg::TOT_W'(1);
          ta_d    = ta_q + soa_pkg::TOT_W'(1);
          if (a_n == soa_pkg::CNT_W'(1)) begin
            rem_en[soa_pkg::LIST_PARTIAL] = 1'b1;
            push_en[soa_pkg::LIST_FULL]   = 1'b1;
            mv_slot                       = a_slot_q;
          end
        end
      end
      soa_pkg::ACT_FREE: begin
        emit = 1'b1;
        if (!f_found) begin
          o_status = soa_pkg::ST_NOT_OWNED;
        end else if (f_n >= cap_q[f_slot]) begin
          o_status = soa_pkg::ST_ALREADY_FREE;
        end else begin
          mem_we  = 1'b1;
          mem_wa  = {f_slot, f_n[soa_pkg::IDX_W-1:0]};
          nf_we   = 1'b1;
          nf_slot = f_slot;
          nf_val  = f_n + soa_pkg::CNT_W'(1);
          low_val = low_q[f_slot];
          tf_d    = tf_q + soa_pkg::TOT_W'(1);
          ta_d    = ta_q - soa_pkg::TOT_W'(1);
          mv_slot = f_slot;
          if (f_n == '0) begin
            rem_en[f_src]                  = 1'b1;
            push_en[soa_pkg::LIST_PARTIAL] = 1'b1;
          end else if (nf_val == cap_q[f_slot]) begin
            rem_en[f_src]                = 1'b1;
            push_en[soa_pkg::LIST_EMPTY] = 1'b1;
          end
        end
      end
      soa_pkg::ACT_SHRINK_NONE: begin
        emit     = 1'b1;
        o_status = soa_pkg::ST_NOTHING_RELEASED;
      end
      soa_pkg::ACT_SHRINK_POP: begin
        emit                        = 1'b1;
        pop_en[soa_pkg::LIST_EMPTY] = 1'b1;
        clr_en                      = 1'b1;
        nf_slot                     = head_e;
        tf_d                        = tf_q - soa_pkg::TOT_W'(cap_q[head_e]);
        sc_d                        = sc_q - soa_pkg::SC_W'(1);
        rel_d                       = rel_q + soa_pkg::SC_W'(1);
        o_rel                       = rel_d;
        o_addr                      = page_q[head_e];
        o_last                      = len_q[soa_pkg::LIST_EMPTY] == soa_pkg::LEN_W'(1);
      end
      default: ;
    endcase
  end

  // List update: remove or pop first, then push onto the new head.
  always_comb begin
    logic                      seen;
    logic [soa_pkg::LEN_W-1:0] rm_len;
    for (int l = 0; l < NL; l++) begin
      seen = 1'b0;
      for (int p = 0; p < NS - 1; p++) begin
        seen = seen || (rem_en[l] && (soa_pkg::LEN_W'(p) < len_q[l]) &&
                        (list_q[l][p] == mv_slot));
        list_d[l][p] = seen ? list_q[l][p+1] : list_q[l][p];
      end
      seen = seen || (rem_en[l] && (soa_pkg::LEN_W'(NS - 1) < len_q[l]) &&
                      (list_q[l][NS-1] == mv_slot));
      list_d[l][NS-1] = list_q[l][NS-1];
      rm_len = len_q[l];
      if (seen || pop_en[l]) rm_len = len_q[l] - soa_pkg::LEN_W'(1);
      len_d[l] = rm_len;
      if (push_en[l]) begin
        list_d[l][soa_pkg::SLOT_W'(rm_len)] = mv_slot;
        len_d[l] = rm_len + soa_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      tf_q        <= '0;
      ta_q        <= '0;
      sc_q        <= '0;
      rel_q       <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NL; l++) len_q[l] <= '0;
    end else begin
      tf_q  <= tf_d;
      ta_q  <= ta_d;
      sc_q  <= sc_d;
      rel_q <= rel_d;
      for (int l = 0; l < NL; l++) len_q[l] <= len_d[l];
      if (add_en) valid_q[mv_slot] <= 1'b1;
      if (clr_en) valid_q[nf_slot] <= 1'b0;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
    if (cmd_i.load) begin
      page_in_q <= page_base_i;
      addr_in_q <= object_address_i;
    end
    if (add_en) begin
      page_q[mv_slot]  <= page_in_q;
      cap_q[mv_slot]   <= cap;
      nfree_q[mv_slot] <= cap;
      osz_q[mv_slot]   <= rounded;
      low_q[mv_slot]   <= cap;
    end
    if (nf_we) begin
      nfree_q[nf_slot] <= nf_val;
      low_q[nf_slot]   <= low_val;
    end
    if (clr_en) nfree_q[nf_slot] <= '0;
    if (cmd_i.act == soa_pkg::ACT_ALLOC_PICK) begin
      a_slot_q <= pick_slot;
      a_none_q <= !(has_p || has_e);
      // Stack entries below the lowest level ever reached still hold their
      // initial addresses, which are rebuilt from the page base.
      a_impl_q <= pick_idx_w < low_q[pick_slot];
      prod_q   <= soa_pkg::PROD_W'(cap_q[pick_slot] - soa_pkg::CNT_W'(1) - pick_idx_w) *
                  soa_pkg::PROD_W'(osz_q[pick_slot]);
    end
    if (cmd_i.act == soa_pkg::ACT_FREE_SCAN) begin
      for (int s = 0; s < NS; s++) begin
        own_q[s] <= (addr_in_q >= page_q[s]) &&
                    ((addr_in_q - page_q[s]) < soa_pkg::ADDR_W'(page_size_q));
      end
    end
    if (emit) begin
      o_status_q <= o_status;
      o_addr_q   <= o_addr;
      o_last_q   <= o_last;
      o_rel_q    <= o_rel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= stack_mem[mem_ra];
  end

  // Totals in the response register always reflect the state after the step.
  logic [soa_pkg::TOT_W-1:0] o_tf_q, o_ta_q;
  logic [soa_pkg::SC_W-1:0]  o_sc_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_tf_q <= tf_d;
      o_ta_q <= ta_d;
      o_sc_q <= sc_d;
    end
  end

  assign sts_o.out_free    = out_free;
  assign sts_o.div_done    = div_done;
  assign sts_o.shrink_none = !rel_en_q || (len_q[soa_pkg::LIST_EMPTY] == '0);
  assign sts_o.shrink_last = len_q[soa_pkg::LIST_EMPTY] == soa_pkg::LEN_W'(1);

  assign out_valid_o         = out_valid_q;
  assign status_o            = o_status_q;
  assign result_address_o    = o_addr_q;
  assign last_o              = o_last_q;
  assign released_count_o    = o_rel_q;
  assign free_objects_o      = o_tf_q;
  assign allocated_objects_o = o_ta_q;
  assign slab_count_o        = o_sc_q;

endmodule

@@ hw/rtl/soa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences each request through the datapath steps of its operation.
// ----------------------------------------------------------------------------
module soa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  soa_pkg::op_e     in_opcode_i,
  output logic             in_ready_o,
  input  soa_pkg::sts_t    sts_i,
  output soa_pkg::cmd_t    cmd_o
);

  soa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= soa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, div_start: 1'b0, act: soa_pkg::ACT_NONE};
    unique case (state_q)
      soa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (in_opcode_i)
            soa_pkg::OP_ADD: begin
              cmd_o.div_start = 1'b1;
              state_d         = soa_pkg::S_ADD_DIV;
            end
            soa_pkg::OP_ALLOC:  state_d = soa_pkg::S_ALLOC_PICK;
            soa_pkg::OP_FREE:   state_d = soa_pkg::S_FREE_SCAN;
            soa_pkg::OP_SHRINK: state_d = soa_pkg::S_SHRINK_CHK;
          endcase
        end
      end
      soa_pkg::S_ADD_DIV: begin
        if (sts_i.div_done) state_d = soa_pkg::S_ADD_DO;
      end
      soa_pkg::S_ADD_DO: begin
        if (sts_i.out_free) begin
          cmd_o.act = soa_pkg::ACT_ADD;
          state_d   = soa_pkg::S_IDLE;
        end
      end
      soa_pkg::S_ALLOC_PICK: begin
        cmd_o.act = soa_pkg::ACT_ALLOC_PICK;
        state_d   = soa_pkg::S_ALLOC_DO;
      end
      soa_pkg::S_ALLOC_DO: begin
        if (sts_i.out_free) begin
          cmd_o.act = soa_pkg::ACT_ALLOC;
          state_d   = soa_pkg::S_IDLE;
        end
      end
      soa_pkg::S_FREE_SCAN: begin
        cmd_o.act = soa_pkg::ACT_FREE_SCAN;
        state_d   = soa_pkg::S_FREE_DO;
      end
      soa_pkg::S_FREE_DO: begin
        if (sts_i.out_free) begin
          cmd_o.act = soa_pkg::ACT_FREE;
          state_d   = soa_pkg::S_IDLE;
        end
      end
      soa_pkg::S_SHRINK_CHK: begin
        if (!sts_i.shrink_none) begin
          state_d = soa_pkg::S_SHRINK_POP;
        end else if (sts_i.out_free) begin
          cmd_o.act = soa_pkg::ACT_SHRINK_NONE;
          state_d   = soa_pkg::S_IDLE;
        end
      end
      soa_pkg::S_SHRINK_POP: begin
        if (sts_i.out_free) begin
          cmd_o.act = soa_pkg::ACT_SHRINK_POP;
          if (sts_i.shrink_last) state_d = soa_pkg::S_IDLE;
        end
      end
      default: state_d = soa_pkg::S_IDLE;
    endcase
  end

endmodule
